### src/rdv_pkg.sv
// Package for the radial devignetting core: shared widths, register indices and the divider result struct.
// No dependencies.
package rdv_pkg;

  localparam int CoordW = 24;
  localparam int CompW  = 16;
  localparam int KW     = 21;
  localparam int GainW  = 15;
  localparam int NumRegs = 5;

  localparam logic [2:0] RegK1    = 3'd0;
  localparam logic [2:0] RegK2    = 3'd1;
  localparam logic [2:0] RegK3    = 3'd2;
  localparam logic [2:0] RegStep  = 3'd3;
  localparam logic [2:0] RegScale = 3'd4;

  // Divider result: the gain together with its valid strobe.
  typedef struct packed {
    logic             valid;
    logic [GainW-1:0] gain;
  } gain_cmd_t;

endpackage

### src/rdv_lane.sv
// One component lane: applies the gain with rounding and saturation.
// Depends on rdv_pkg.
module rdv_lane #(
  parameter int GainFrac = 10
) (
  input  logic [rdv_pkg::CompW-1:0] comp_i,
  input  logic [rdv_pkg::GainW-1:0] gain_i,
  output logic [rdv_pkg::CompW-1:0] out_o
);
  logic [rdv_pkg::CompW+rdv_pkg::GainW:0] prod;
  logic [rdv_pkg::CompW+rdv_pkg::GainW:0] shf;
  localparam logic [rdv_pkg::CompW+rdv_pkg::GainW:0] Half =
    (rdv_pkg::CompW+rdv_pkg::GainW+1)'(1) << (GainFrac-1);

  always_comb begin
    prod = (rdv_pkg::CompW+rdv_pkg::GainW+1)'(comp_i) *
           (rdv_pkg::CompW+rdv_pkg::GainW+1)'(gain_i) + Half;
    shf  = prod >> GainFrac;
    out_o = (|shf[rdv_pkg::CompW+rdv_pkg::GainW:rdv_pkg::CompW]) ?
            {rdv_pkg::CompW{1'b1}} : shf[rdv_pkg::CompW-1:0];
  end
endmodule

### src/rdv_div.sv
// Restoring divider: gain = 2^(GainFrac+20) / c, one quotient bit per cycle.
// Depends on rdv_pkg.
module rdv_div #(
  parameter int GainFrac = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [47:0]         den_i,
  output rdv_pkg::gain_cmd_t         res_o
);
  localparam int NumW = GainFrac + 21;
  localparam int CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [47:0]     den_q, den_d;
  logic [48:0]     rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic            done_q, done_d;
  logic [48:0]     trial;
  logic [NumW-1:0] numer;

  assign numer = NumW'(1) << (GainFrac + 20);

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; den_d = den_q; rem_d = rem_q;
    quo_d = quo_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      if (den_i <= 0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        den_d  = '0;
      end
    end else if (busy_q) begin
      trial = {rem_q[47:0], numer[cnt_q - CntW'(1)]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d; rem_q <= rem_d; quo_q <= quo_d;
  end

  always_comb begin
    res_o.valid = done_q;
    if (den_q == '0) res_o.gain = '0;
    else if (|quo_q[NumW-1:rdv_pkg::GainW]) res_o.gain = {rdv_pkg::GainW{1'b1}};
    else res_o.gain = quo_q[rdv_pkg::GainW-1:0];
  end
endmodule

### src/radial_devignetting_rgba16_core.sv
// Top level of the radial devignetting core: sequencer, polynomial, divider, lanes.
// Depends on rdv_pkg, rdv_div and rdv_lane.
//
// Each beat carries one pixel. A row-start beat loads x and y as the centered start
// coordinates times coordinate_scale; every beat then advances x by coordinate_step.
// The gain 1/(1 + k1*r2 + k2*r4 + k3*r6) is computed with one 29 by 29 bit multiplier
// stepped through twelve sequencer steps (the wide products r4*r2, k2*r4 and k3*r6 are
// split into a low and a high half) and a bit-serial divider, and four lanes apply it
// to the components in parallel. After the multiplier steps (a row-start pixel adds
// the two load steps) the divider loop runs, then a wait step and an output step, and
// the sequencer returns to idle for the next pixel. When the denominator is not
// positive the divider finishes at once. A stalled output holds the output step.
// The result sits in an output register, so the next pixel is taken while it waits.
module radial_devignetting_rgba16_core #(
  parameter int GAIN_FRACTION_BITS = 10,
  parameter int COMPONENTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [20:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: start_x[15:0], start_y[31:16], comp_a..comp_d [95:32]
  input  logic [95:0] s_axis_tdata,
  // tuser: row_start
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_a[15:0], out_b, out_c, out_d[63:48]
  output logic [63:0] m_axis_tdata
);
  localparam logic [3:0] StIdle = 4'd0, StLoadX = 4'd1, StLoadY = 4'd2, StXx = 4'd3,
    StYy = 4'd4, StR4 = 4'd5, StR6a = 4'd6, StR6b = 4'd7, StC1 = 4'd8, StC2a = 4'd9,
    StC2b = 4'd10, StC3a = 4'd11, StC3b = 4'd12, StDiv = 4'd13, StWait = 4'd14,
    StOut = 4'd15;

  logic signed [20:0] k1_q, k2_q, k3_q;
  logic [19:0] step_q, scale_q;
  logic signed [23:0] x_q, x_d, y_q, y_d;
  logic [3:0] st_q, st_d;
  logic [63:0] comps_q;
  logic [31:0] start_q;
  logic signed [63:0] acc_q, acc_d;
  logic [27:0] r2_q, r2_d;
  logic [34:0] r4_q, r4_d;
  logic [41:0] r6_q, r6_d;
  logic signed [47:0] c_q, c_d;
  logic signed [28:0] pa, pb;
  logic signed [57:0] prod;
  logic signed [49:0] satv;
  logic div_start;
  rdv_pkg::gain_cmd_t gcmd;
  logic [rdv_pkg::GainW-1:0] gain_q;
  logic [63:0] lane_out, obuf_q;
  logic ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q <= '0; k2_q <= '0; k3_q <= '0; step_q <= '0; scale_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rdv_pkg::RegK1:    k1_q <= cfg_data_i;
        rdv_pkg::RegK2:    k2_q <= cfg_data_i;
        rdv_pkg::RegK3:    k3_q <= cfg_data_i;
        rdv_pkg::RegStep:  step_q <= cfg_data_i[19:0];
        rdv_pkg::RegScale: scale_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (st_q == StIdle);

  // Shared multiplier operands for each sequencer step. Wide factors are split at
  // bit 28 and the two partial products are summed in the accumulator.
  always_comb begin
    pa = '0; pb = '0;
    unique case (st_q)
      StLoadX: begin pa = 29'(signed'(start_q[15:0])); pb = 29'({1'b0, scale_q}); end
      StLoadY: begin pa = 29'(signed'(start_q[31:16])); pb = 29'({1'b0, scale_q}); end
      StXx:    begin pa = 29'(x_q); pb = 29'(x_q); end
      StYy:    begin pa = 29'(y_q); pb = 29'(y_q); end
      StR4:    begin pa = {1'b0, r2_q}; pb = {1'b0, r2_q}; end
      StR6a:   begin pa = {1'b0, r4_q[27:0]}; pb = {1'b0, r2_q}; end
      StR6b:   begin pa = 29'({1'b0, r4_q[34:28]}); pb = {1'b0, r2_q}; end
      StC1:    begin pa = 29'(k1_q); pb = {1'b0, r2_q}; end
      StC2a:   begin pa = 29'(k2_q); pb = {1'b0, r4_q[27:0]}; end
      StC2b:   begin pa = 29'(k2_q); pb = 29'({1'b0, r4_q[34:28]}); end
      StC3a:   begin pa = 29'(k3_q); pb = {1'b0, r6_q[27:0]}; end
      StC3b:   begin pa = 29'(k3_q); pb = 29'({1'b0, r6_q[41:28]}); end
      default: ;
    endcase
    prod = 58'(pa) * 58'(pb);
  end

  // Coordinate saturation to 24 bits.
  function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
    if (v > 50'sd8388607) return 24'sh7FFFFF;
    if (v < -50'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  always_comb begin
    st_d = st_q; x_d = x_q; y_d = y_q; acc_d = acc_q;
    r2_d = r2_q; r4_d = r4_q; r6_d = r6_q; c_d = c_q; div_start = 1'b0;
    satv = '0;
    unique case (st_q)
      StIdle: if (s_axis_tvalid) st_d = s_axis_tuser ? StLoadX : StXx;
      StLoadX: begin satv = prod[49:0]; x_d = sat24(satv); st_d = StLoadY; end
      StLoadY: begin satv = prod[49:0]; y_d = sat24(satv); st_d = StXx; end
      StXx: begin acc_d = 64'(prod); st_d = StYy; end
      StYy: begin r2_d = 28'((acc_q + 64'(prod)) >>> 20); st_d = StR4; end
      StR4: begin r4_d = prod[54:20]; st_d = StR6a; end
      StR6a: begin acc_d = 64'(prod); st_d = StR6b; end
      StR6b: begin
        r6_d = 42'((acc_q + (64'(prod) <<< 28)) >>> 20);
        st_d = StC1;
      end
      StC1: begin c_d = 48'sd1048576 + 48'(prod >>> 16); st_d = StC2a; end
      StC2a: begin acc_d = 64'(prod); st_d = StC2b; end
      StC2b: begin
        c_d = c_q + 48'((acc_q + (64'(prod) <<< 28)) >>> 16);
        st_d = StC3a;
      end
      StC3a: begin acc_d = 64'(prod); st_d = StC3b; end
      StC3b: begin
        c_d = c_q + 48'((acc_q + (64'(prod) <<< 28)) >>> 16);
        div_start = 1'b1;
        st_d = StDiv;
      end
      StDiv: if (gcmd.valid) st_d = StWait;
      StWait: st_d = StOut;
      StOut: if (!ovalid_q || m_axis_tready) begin
        satv = 50'(x_q) + 50'({1'b0, step_q});
        x_d = sat24(satv);
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; x_q <= '0; y_q <= '0;
    end else begin
      st_q <= st_d; x_q <= x_d; y_q <= y_d;
    end
  end

  // The whole input beat is captured at acceptance; the source may change it after.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; r2_q <= r2_d; r4_q <= r4_d; r6_q <= r6_d; c_q <= c_d;
    if (s_axis_tvalid && s_axis_tready) begin
      comps_q <= s_axis_tdata[95:32];
      start_q <= s_axis_tdata[31:0];
    end
    if (gcmd.valid) gain_q <= gcmd.gain;
  end

  rdv_div #(.GainFrac(GAIN_FRACTION_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .den_i(c_d), .res_o(gcmd)
  );

  for (genvar l = 0; l < 4; l++) begin : g_lane
    if (l < COMPONENTS) begin : g_on
      rdv_lane #(.GainFrac(GAIN_FRACTION_BITS)) u_lane (
        .comp_i(comps_q[16*l +: 16]), .gain_i(gain_q), .out_o(lane_out[16*l +: 16])
      );
    end else begin : g_off
      assign lane_out[16*l +: 16] = '0;
    end
  end

  // Merge stage: the lane results are registered together as one output beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (st_q == StOut && (!ovalid_q || m_axis_tready)) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StOut && (!ovalid_q || m_axis_tready)) obuf_q <= lane_out;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = obuf_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped under stall");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second pixel taken while one is in flight");
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcmd.valid |-> st_q == StDiv)
    else $error("divider finished outside its step");
endmodule
